@@ hdl/laplace_gauss_seidel_solver_macros.svh @@
// assertion macros shared by the laplace solver rtl
`ifndef LAPLACE_GAUSS_SEIDEL_SOLVER_MACROS_SVH
`define LAPLACE_GAUSS_SEIDEL_SOLVER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define LGS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define LGS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lgs_pkg.sv @@
// types, codes and control store for the laplace solver
package lgs_pkg;

  localparam int GRID_SIZE_DEF = 32;

  localparam int KIND_W    = 2;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int TOL_W     = 16;
  localparam int SWEEP_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = VAL_W + 2;

  localparam logic [VAL_W-1:0]   TOP_EDGE_RST   = 32'd6553600;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST  = 16'd1;
  localparam logic [SWEEP_W-1:0] MAX_SWEEPS_RST = 16'd4096;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_EDGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = 2'd2;

  // microprogram steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] U_IDLE        = 5'd0;
  localparam logic [STEP_W-1:0] U_READ_OUT    = 5'd1;
  localparam logic [STEP_W-1:0] U_INIT_WR     = 5'd2;
  localparam logic [STEP_W-1:0] U_INIT_END    = 5'd3;
  localparam logic [STEP_W-1:0] U_SOLVE_START = 5'd4;
  localparam logic [STEP_W-1:0] U_SWEEP_START = 5'd5;
  localparam logic [STEP_W-1:0] U_ROW_RD_W    = 5'd6;
  localparam logic [STEP_W-1:0] U_RD_NS_W     = 5'd7;
  localparam logic [STEP_W-1:0] U_RD_NS       = 5'd8;
  localparam logic [STEP_W-1:0] U_RD_EC       = 5'd9;
  localparam logic [STEP_W-1:0] U_ADD_S       = 5'd10;
  localparam logic [STEP_W-1:0] U_ADD_E       = 5'd11;
  localparam logic [STEP_W-1:0] U_WRITE       = 5'd12;
  localparam logic [STEP_W-1:0] U_CMP         = 5'd13;
  localparam logic [STEP_W-1:0] U_ROW_END     = 5'd14;
  localparam logic [STEP_W-1:0] U_SWEEP_END   = 5'd15;
  localparam logic [STEP_W-1:0] U_SOLVE_OUT   = 5'd16;

  // read port a address source
  localparam int ASEL_W = 3;
  localparam logic [ASEL_W-1:0] A_IN  = 3'd0;
  localparam logic [ASEL_W-1:0] A_REQ = 3'd1;
  localparam logic [ASEL_W-1:0] A_N   = 3'd2;
  localparam logic [ASEL_W-1:0] A_W   = 3'd3;
  localparam logic [ASEL_W-1:0] A_E   = 3'd4;

  // read port b address source
  localparam logic B_S = 1'b0;
  localparam logic B_C = 1'b1;

  // datapath actions
  localparam int ACT_W = 4;
  localparam logic [ACT_W-1:0] ACT_NONE       = 4'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_READ  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_INIT_WR    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_SOLVE_CLR  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_SWEEP_INIT = 4'd4;
  localparam logic [ACT_W-1:0] ACT_ACC_W_RAM  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_ACC_W      = 4'd6;
  localparam logic [ACT_W-1:0] ACT_ACC_N      = 4'd7;
  localparam logic [ACT_W-1:0] ACT_ACC_S      = 4'd8;
  localparam logic [ACT_W-1:0] ACT_ACC_E      = 4'd9;
  localparam logic [ACT_W-1:0] ACT_WRITE      = 4'd10;
  localparam logic [ACT_W-1:0] ACT_CMP_COL    = 4'd11;
  localparam logic [ACT_W-1:0] ACT_NEXT_ROW   = 4'd12;
  localparam logic [ACT_W-1:0] ACT_SWEEP_DONE = 4'd13;
  localparam logic [ACT_W-1:0] ACT_LOAD_SOLVE = 4'd14;

  // sequencing conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT        = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS      = 3'd1;
  localparam logic [COND_W-1:0] C_DISPATCH    = 3'd2;
  localparam logic [COND_W-1:0] C_COL_MORE    = 3'd3;
  localparam logic [COND_W-1:0] C_ROW_MORE    = 3'd4;
  localparam logic [COND_W-1:0] C_GRID_MORE   = 3'd5;
  localparam logic [COND_W-1:0] C_NO_SWEEPS   = 3'd6;
  localparam logic [COND_W-1:0] C_SWEEP_AGAIN = 3'd7;

  typedef struct packed {
    logic [ASEL_W-1:0] a_sel;
    logic              b_sel;
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic              wait_out;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic              in_fire;
    logic [KIND_W-1:0] kind;
    logic              out_free;
    logic              col_more;
    logic              row_more;
    logic              grid_more;
    logic              no_sweeps;
    logic              sweep_again;
  } seq_flags_t;

  // control store
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{a_sel: A_N, b_sel: B_S, act: ACT_NONE, cond: C_NEXT,
          wait_out: 1'b0, target: U_IDLE};
    unique case (step)
      U_IDLE:        begin w.a_sel = A_IN; w.cond = C_DISPATCH; end
      U_READ_OUT:    begin
        w.a_sel = A_REQ; w.act = ACT_LOAD_READ; w.wait_out = 1'b1;
        w.cond = C_ALWAYS; w.target = U_IDLE;
      end
      U_INIT_WR:     begin
        w.act = ACT_INIT_WR; w.cond = C_GRID_MORE; w.target = U_INIT_WR;
      end
      U_INIT_END:    begin w.cond = C_ALWAYS; w.target = U_IDLE; end
      U_SOLVE_START: begin
        w.act = ACT_SOLVE_CLR; w.cond = C_NO_SWEEPS; w.target = U_SOLVE_OUT;
      end
      U_SWEEP_START: w.act = ACT_SWEEP_INIT;
      U_ROW_RD_W:    w.a_sel = A_W;
      U_RD_NS_W:     begin
        w.act = ACT_ACC_W_RAM; w.cond = C_ALWAYS; w.target = U_RD_EC;
      end
      U_RD_NS:       w.act = ACT_ACC_W;
      U_RD_EC:       begin w.a_sel = A_E; w.b_sel = B_C; w.act = ACT_ACC_N; end
      U_ADD_S:       w.act = ACT_ACC_S;
      U_ADD_E:       w.act = ACT_ACC_E;
      U_WRITE:       w.act = ACT_WRITE;
      U_CMP:         begin
        w.act = ACT_CMP_COL; w.cond = C_COL_MORE; w.target = U_RD_NS;
      end
      U_ROW_END:     begin
        w.act = ACT_NEXT_ROW; w.cond = C_ROW_MORE; w.target = U_ROW_RD_W;
      end
      U_SWEEP_END:   begin
        w.act = ACT_SWEEP_DONE; w.cond = C_SWEEP_AGAIN; w.target = U_SWEEP_START;
      end
      U_SOLVE_OUT:   begin
        w.act = ACT_LOAD_SOLVE; w.wait_out = 1'b1;
        w.cond = C_ALWAYS; w.target = U_IDLE;
      end
      default:       begin w.cond = C_ALWAYS; w.target = U_IDLE; end
    endcase
    return w;
  endfunction

endpackage

@@ hdl/laplace_gauss_seidel_solver.sv @@
// laplace solver top level: grid memory, datapath, sequencer and handshakes
//
// Holds a GRID_SIZE x GRID_SIZE grid of signed Q16.16 cells in one block ram
// and relaxes it in place with five-point Gauss-Seidel sweeps. A write item
// is written as it is taken and the block is ready again at once; a read
// item goes to its read-out step, which loads the registered ram data into
// the output register once that register is free. An init item walks every
// cell, one per cycle. In a solve item's sweeps, the microprogram steps for
// each interior cell are set by the two ram read ports (north/south, then
// east/centre) and a single 34-bit accumulator that adds one neighbour per
// cycle; the west neighbour is carried from the previous cell, or read from
// the ram for the first cell of a row. Items are
// taken only while the sequencer sits in its idle step; a finished result
// waits in the output register, and the block goes on taking writes and
// inits while it waits. The grid has no reset: cells read before being
// written (or before an init) give undefined values.
module laplace_gauss_seidel_solver #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // item input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lgs_pkg::KIND_W-1:0]        kind,
  input  logic [lgs_pkg::POS_W-1:0]         row,
  input  logic [lgs_pkg::POS_W-1:0]         col,
  input  logic signed [lgs_pkg::VAL_W-1:0]  cell_value,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lgs_pkg::VAL_W-1:0]  read_value,
  output logic [lgs_pkg::SWEEP_W-1:0]       sweeps_used,
  output logic                              converged,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lgs_pkg::VAL_W-1:0]         cfg_data
);

`include "laplace_gauss_seidel_solver_macros.svh"

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(GRID_SIZE);
  localparam int VW    = lgs_pkg::VAL_W;
  localparam int SW    = lgs_pkg::SWEEP_W;
  localparam int CW    = lgs_pkg::ACC_W;

  localparam logic [IW-1:0] LAST_CELL = IW'(GRID_SIZE - 1);
  localparam logic [IW-1:0] LAST_IN   = IW'(GRID_SIZE - 2);

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
    return AW'(r) * AW'(GRID_SIZE) + AW'(c);
  endfunction

  // configuration registers
  logic signed [VW-1:0] top_edge_value;
  logic [lgs_pkg::TOL_W-1:0] tolerance;
  logic [SW-1:0]        max_sweeps;

  // sequencer
  lgs_pkg::uword_t            ctl;
  lgs_pkg::seq_flags_t        flags;
  logic [lgs_pkg::STEP_W-1:0] step;
  logic                       go;

  // walk and solve state
  logic [IW-1:0]  walk_row;
  logic [IW-1:0]  walk_col;
  logic [SW-1:0]  sweep_count;
  logic [VW-1:0]  max_change;
  logic           solve_conv;

  // datapath registers (no reset)
  logic signed [CW-1:0] acc;
  logic signed [VW-1:0] west;
  logic signed [VW-1:0] hold;
  logic signed [VW-1:0] old;
  logic signed [VW:0]   diff;
  logic [AW-1:0]        req_addr;
  logic                 req_inside;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  logic [VW-1:0] ram_rdata_a;
  logic [VW-1:0] ram_rdata_b;

  // misc combinational
  logic                 in_fire;
  logic                 in_inside;
  logic [AW-1:0]        in_addr;
  logic [AW-1:0]        walk_addr;
  logic                 out_free;
  logic                 out_load;
  logic signed [VW-1:0] nv;
  logic signed [VW-1:0] init_value;
  logic signed [VW-1:0] acc_operand;
  logic signed [CW-1:0] acc_sum;
  logic [VW:0]          mag;
  logic [VW-1:0]        change;
  logic                 within_tol;
  logic [SW:0]          sweeps_plus;

  // item handshake: items enter only at the idle step
  assign in_ready  = (step == lgs_pkg::U_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_inside = (int'(row) < GRID_SIZE) && (int'(col) < GRID_SIZE);
  assign in_addr   = cell_addr(IW'(row), IW'(col));
  assign walk_addr = cell_addr(walk_row, walk_col);

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  assign out_load = go && (ctl.act == lgs_pkg::ACT_LOAD_READ ||
                           ctl.act == lgs_pkg::ACT_LOAD_SOLVE);

  // new cell value is floor(sum / 4) of the 34-bit neighbour sum
  assign nv = acc[CW-1:2];

  // top row takes the edge value except at its two corners
  assign init_value = (walk_row == '0 && walk_col != '0 && walk_col != LAST_CELL) ?
                      top_edge_value : '0;

  // absolute change, saturated to 32 bits
  assign mag    = diff[VW] ? (~diff + (VW+1)'(1)) : diff;
  assign change = mag[VW] ? {VW{1'b1}} : mag[VW-1:0];

  assign within_tol  = (max_change <= VW'(tolerance));
  assign sweeps_plus = {1'b0, sweep_count} + (SW+1)'(1);

  assign flags.in_fire     = in_fire;
  assign flags.kind        = kind;
  assign flags.out_free    = out_free;
  assign flags.col_more    = (walk_col != LAST_IN);
  assign flags.row_more    = (walk_row != LAST_IN);
  assign flags.grid_more   = !(walk_row == LAST_CELL && walk_col == LAST_CELL);
  assign flags.no_sweeps   = (max_sweeps == '0);
  assign flags.sweep_again = !within_tol && (sweeps_plus < {1'b0, max_sweeps});

  lgs_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl),
    .step  (step),
    .go    (go)
  );

  // read address selection
  always_comb begin
    unique case (ctl.a_sel)
      lgs_pkg::A_IN:  ram_raddr_a = in_addr;
      lgs_pkg::A_REQ: ram_raddr_a = req_addr;
      lgs_pkg::A_N:   ram_raddr_a = cell_addr(walk_row - IW'(1), walk_col);
      lgs_pkg::A_W:   ram_raddr_a = cell_addr(walk_row, walk_col - IW'(1));
      lgs_pkg::A_E:   ram_raddr_a = cell_addr(walk_row, walk_col + IW'(1));
      default:        ram_raddr_a = in_addr;
    endcase
  end

  assign ram_raddr_b = (ctl.b_sel == lgs_pkg::B_C) ? walk_addr :
                       cell_addr(walk_row + IW'(1), walk_col);

  // write port: host writes at idle, init fill, relaxed cell
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = walk_addr;
    ram_wdata = nv;
    if (in_fire) begin
      ram_we    = (kind == lgs_pkg::KIND_WRITE) && in_inside;
      ram_waddr = in_addr;
      ram_wdata = cell_value;
    end else if (ctl.act == lgs_pkg::ACT_INIT_WR) begin
      ram_we    = 1'b1;
      ram_wdata = init_value;
    end else if (ctl.act == lgs_pkg::ACT_WRITE) begin
      ram_we    = 1'b1;
    end
  end

  lgs_ram #(
    .WIDTH (VW),
    .DEPTH (CELLS)
  ) u_grid (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // single accumulator: one neighbour added per step
  always_comb begin
    unique case (ctl.act)
      lgs_pkg::ACT_ACC_N: acc_operand = ram_rdata_a;
      default:            acc_operand = hold;
    endcase
  end
  assign acc_sum = acc + CW'(acc_operand);

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      top_edge_value <= lgs_pkg::TOP_EDGE_RST;
      tolerance      <= lgs_pkg::TOLERANCE_RST;
      max_sweeps     <= lgs_pkg::MAX_SWEEPS_RST;
      out_valid      <= 1'b0;
      walk_row       <= '0;
      walk_col       <= '0;
      sweep_count    <= '0;
      max_change     <= '0;
      solve_conv     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lgs_pkg::CFG_TOP_EDGE:   top_edge_value <= cfg_data;
          lgs_pkg::CFG_TOLERANCE:  tolerance <= cfg_data[lgs_pkg::TOL_W-1:0];
          lgs_pkg::CFG_MAX_SWEEPS: max_sweeps <= cfg_data[SW-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (in_fire && kind == lgs_pkg::KIND_INIT) begin
        walk_row <= '0;
        walk_col <= '0;
      end

      if (go) begin
        unique case (ctl.act)
          lgs_pkg::ACT_INIT_WR: begin
            if (walk_col == LAST_CELL) begin
              walk_col <= '0;
              walk_row <= walk_row + IW'(1);
            end else begin
              walk_col <= walk_col + IW'(1);
            end
          end
          lgs_pkg::ACT_SOLVE_CLR: begin
            sweep_count <= '0;
            solve_conv  <= 1'b0;
          end
          lgs_pkg::ACT_SWEEP_INIT: begin
            walk_row   <= IW'(1);
            walk_col   <= IW'(1);
            max_change <= '0;
          end
          lgs_pkg::ACT_CMP_COL: begin
            if (change > max_change) begin
              max_change <= change;
            end
            if (flags.col_more) begin
              walk_col <= walk_col + IW'(1);
            end
          end
          lgs_pkg::ACT_NEXT_ROW: begin
            if (flags.row_more) begin
              walk_row <= walk_row + IW'(1);
              walk_col <= IW'(1);
            end
          end
          lgs_pkg::ACT_SWEEP_DONE: begin
            sweep_count <= sweeps_plus[SW-1:0];
            solve_conv  <= within_tol;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_addr   <= in_addr;
      req_inside <= in_inside;
    end
    if (go) begin
      unique case (ctl.act)
        lgs_pkg::ACT_LOAD_READ: begin
          read_value  <= req_inside ? ram_rdata_a : '0;
          sweeps_used <= '0;
          converged   <= 1'b0;
        end
        lgs_pkg::ACT_LOAD_SOLVE: begin
          read_value  <= '0;
          sweeps_used <= sweep_count;
          converged   <= solve_conv;
        end
        lgs_pkg::ACT_ACC_W_RAM: begin
          // first cell of a row: west neighbour comes from the boundary column
          west <= ram_rdata_a;
          acc  <= CW'($signed(ram_rdata_a));
        end
        lgs_pkg::ACT_ACC_W: acc <= CW'(west);
        lgs_pkg::ACT_ACC_N: begin
          acc  <= acc_sum;
          hold <= ram_rdata_b;
        end
        lgs_pkg::ACT_ACC_S: begin
          acc  <= acc_sum;
          hold <= ram_rdata_a;
          old  <= ram_rdata_b;
        end
        lgs_pkg::ACT_ACC_E: acc <= acc_sum;
        lgs_pkg::ACT_WRITE: begin
          // relaxed value becomes the next cell's west neighbour
          west <= nv;
          diff <= (VW+1)'(nv) - (VW+1)'(old);
        end
        default: ;
      endcase
    end
  end

  // a converged solve has run at least one sweep
  `LGS_ASSERT_IMP(a_conv_has_sweep, out_valid && converged, sweeps_used != 16'd0, "converged with no sweep")
  // relaxation writes only land on interior cells
  `LGS_ASSERT_IMP(a_write_interior, step == lgs_pkg::U_WRITE, walk_row != '0 && walk_col != '0 && walk_row != LAST_CELL && walk_col != LAST_CELL, "relaxation outside interior")
  // a solve never reports more sweeps than the limit
  `LGS_ASSERT_IMP(a_sweep_bound, step == lgs_pkg::U_SOLVE_OUT, sweep_count <= max_sweeps, "sweep limit exceeded")
  // a read item always goes straight to its read-out step
  `LGS_ASSERT_NXT(a_read_path, in_valid && in_ready && kind == lgs_pkg::KIND_READ, step == lgs_pkg::U_READ_OUT, "read item lost its read-out step")

endmodule

@@ hdl/lgs_ram.sv @@
// generic single-write dual-read ram with registered read data
module lgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hdl/lgs_seq.sv @@
// microprogram sequencer: step counter, control store and jump logic
module lgs_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  lgs_pkg::seq_flags_t           flags,
  output lgs_pkg::uword_t               ctl,
  output logic [lgs_pkg::STEP_W-1:0]    step,
  output logic                          go
);

  logic [lgs_pkg::STEP_W-1:0] step_next;
  logic [lgs_pkg::STEP_W-1:0] step_inc;
  logic [lgs_pkg::STEP_W-1:0] dispatch;
  logic                       taken;

  assign ctl      = lgs_pkg::ucode(step);
  assign go       = !(ctl.wait_out && !flags.out_free);
  assign step_inc = step + lgs_pkg::STEP_W'(1);

  always_comb begin
    unique case (flags.kind)
      lgs_pkg::KIND_WRITE: dispatch = lgs_pkg::U_IDLE;
      lgs_pkg::KIND_SOLVE: dispatch = lgs_pkg::U_SOLVE_START;
      lgs_pkg::KIND_READ:  dispatch = lgs_pkg::U_READ_OUT;
      lgs_pkg::KIND_INIT:  dispatch = lgs_pkg::U_INIT_WR;
      default:             dispatch = lgs_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    unique case (ctl.cond)
      lgs_pkg::C_NEXT:        taken = 1'b0;
      lgs_pkg::C_ALWAYS:      taken = 1'b1;
      lgs_pkg::C_DISPATCH:    taken = 1'b0;
      lgs_pkg::C_COL_MORE:    taken = flags.col_more;
      lgs_pkg::C_ROW_MORE:    taken = flags.row_more;
      lgs_pkg::C_GRID_MORE:   taken = flags.grid_more;
      lgs_pkg::C_NO_SWEEPS:   taken = flags.no_sweeps;
      lgs_pkg::C_SWEEP_AGAIN: taken = flags.sweep_again;
      default:                taken = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      step_next = step;
    end else if (ctl.cond == lgs_pkg::C_DISPATCH) begin
      step_next = flags.in_fire ? dispatch : lgs_pkg::U_IDLE;
    end else if (taken) begin
      step_next = ctl.target;
    end else begin
      step_next = step_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lgs_pkg::U_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ tb/sv/laplace_gauss_seidel_solver_test.sv @@
// self-checking testbench for the laplace gauss-seidel solver
`timescale 1ns / 100ps

module laplace_gauss_seidel_solver_test;

  localparam int N = lgs_pkg::GRID_SIZE_DEF;
  // an init walks every cell once, so this covers any work left after the last result
  localparam int SETTLE_CYCLES = N * N + 64;
  // limit for the whole run, set well above the slowest correct run
  localparam longint CYCLE_LIMIT = 64'd4_000_000;
  localparam int PHASE_ITEMS = 165;
  localparam int RANDOM_PHASES = 8;

  typedef struct {
    logic [lgs_pkg::KIND_W-1:0]       kind;
    logic [lgs_pkg::POS_W-1:0]        row;
    logic [lgs_pkg::POS_W-1:0]        col;
    logic signed [lgs_pkg::VAL_W-1:0] value;
  } item_t;

  typedef struct {
    logic signed [lgs_pkg::VAL_W-1:0] value;
    logic [lgs_pkg::SWEEP_W-1:0]      sweeps;
    logic                             settled;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [lgs_pkg::KIND_W-1:0]       kind = lgs_pkg::KIND_WRITE;
  logic [lgs_pkg::POS_W-1:0]        row = '0;
  logic [lgs_pkg::POS_W-1:0]        col = '0;
  logic signed [lgs_pkg::VAL_W-1:0] cell_value = '0;

  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [lgs_pkg::VAL_W-1:0] read_value;
  logic [lgs_pkg::SWEEP_W-1:0]      sweeps_used;
  logic                             converged;

  logic                             cfg_we = 1'b0;
  logic [lgs_pkg::CFG_IDX_W-1:0]    cfg_index = lgs_pkg::CFG_TOP_EDGE;
  logic [lgs_pkg::VAL_W-1:0]        cfg_data = '0;

  // items waiting for the driver, results waiting for the monitor
  item_t    pending_items[$];
  outcome_t due_results[$];

  int     items_offered = 0;
  int     items_taken = 0;
  int     fail_count = 0;
  longint cycle_count = 0;
  int     hold_left = 0;
  int     stall_left = 0;
  bit     calm = 1'b0;

  // shadow of the block: grid contents and register settings
  logic signed [lgs_pkg::VAL_W-1:0] grid_model [N][N];
  logic signed [lgs_pkg::VAL_W-1:0] top_row_shadow = lgs_pkg::TOP_EDGE_RST;
  logic [lgs_pkg::TOL_W-1:0]        tol_shadow = lgs_pkg::TOLERANCE_RST;
  logic [lgs_pkg::SWEEP_W-1:0]      limit_shadow = lgs_pkg::MAX_SWEEPS_RST;

  laplace_gauss_seidel_solver #(
    .GRID_SIZE(N)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .sweeps_used(sweeps_used),
    .converged  (converged),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // one in-place sweep over the interior, returns the largest absolute change
  function automatic logic [lgs_pkg::VAL_W-1:0] relax_once();
    longint neighbours;
    longint delta;
    logic signed [lgs_pkg::VAL_W-1:0] fresh;
    logic [lgs_pkg::VAL_W-1:0] worst;
    worst = '0;
    for (int r = 1; r < N - 1; r++) begin
      for (int c = 1; c < N - 1; c++) begin
        neighbours = longint'(grid_model[r-1][c]) + longint'(grid_model[r+1][c]) +
                     longint'(grid_model[r][c-1]) + longint'(grid_model[r][c+1]);
        // floor of the quarter, always fits back into 32 bits
        fresh = lgs_pkg::VAL_W'(neighbours >>> 2);
        delta = longint'(fresh) - longint'(grid_model[r][c]);
        if (delta < 0) delta = -delta;
        if (lgs_pkg::VAL_W'(delta) > worst) worst = lgs_pkg::VAL_W'(delta);
        grid_model[r][c] = fresh;
      end
    end
    return worst;
  endfunction

  // applies one transferred item to the shadow grid, returns 1 if it gives a result
  function automatic bit predict_item(input item_t it, output outcome_t res);
    logic [lgs_pkg::SWEEP_W-1:0] done_sweeps;
    logic settled;
    res.value = '0;
    res.sweeps = '0;
    res.settled = 1'b0;
    case (it.kind)
      lgs_pkg::KIND_WRITE: begin
        grid_model[it.row][it.col] = it.value;
        return 1'b0;
      end
      lgs_pkg::KIND_INIT: begin
        // top row gets the edge value, corners and everything else zero
        for (int r = 0; r < N; r++)
          for (int c = 0; c < N; c++)
            grid_model[r][c] = (r == 0 && c > 0 && c < N - 1) ? top_row_shadow : '0;
        return 1'b0;
      end
      lgs_pkg::KIND_READ: begin
        res.value = grid_model[it.row][it.col];
        return 1'b1;
      end
      default: begin
        // solve: a sweep limit of zero runs nothing and reports unconverged
        done_sweeps = '0;
        settled = 1'b0;
        while (!settled && done_sweeps < limit_shadow) begin
          settled = (relax_once() <= lgs_pkg::VAL_W'(tol_shadow));
          done_sweeps++;
        end
        res.sweeps = done_sweeps;
        res.settled = settled;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(12, 60);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  // full-range value with the extremes turning up often, or a small one when narrow
  function automatic logic signed [lgs_pkg::VAL_W-1:0] pick_value(input bit narrow);
    if (narrow) return $urandom_range(0, 512) - 256;
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_item(input logic [lgs_pkg::KIND_W-1:0] k,
                                    input logic [lgs_pkg::POS_W-1:0] r,
                                    input logic [lgs_pkg::POS_W-1:0] c,
                                    input logic signed [lgs_pkg::VAL_W-1:0] v);
    item_t it;
    it.kind = k;
    it.row = r;
    it.col = c;
    it.value = v;
    pending_items.push_back(it);
  endfunction

  task automatic write_register(input logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lgs_pkg::VAL_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_registers(input logic signed [lgs_pkg::VAL_W-1:0] top_row,
                               input logic [lgs_pkg::TOL_W-1:0] tol,
                               input logic [lgs_pkg::SWEEP_W-1:0] limit);
    write_register(lgs_pkg::CFG_TOP_EDGE, top_row);
    write_register(lgs_pkg::CFG_TOLERANCE, {16'd0, tol});
    write_register(lgs_pkg::CFG_MAX_SWEEPS, {16'd0, limit});
    top_row_shadow = top_row;
    tol_shadow = tol;
    limit_shadow = limit;
  endtask

  // hold the sender until every transfer is in and every result is out,
  // then let a trailing init finish before anything else happens
  task automatic quiesce();
    while (pending_items.size() != 0 || items_taken != items_offered ||
           due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // driver: presents the next pending item at the falling edge, holding it
  // until the transfer, with a random gap after each one
  always @(negedge clk) begin : feed_items
    item_t next_item;
    if (!rst && !(in_valid && items_taken != items_offered)) begin
      if (hold_left > 0) begin
        hold_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        kind <= next_item.kind;
        row <= next_item.row;
        col <= next_item.col;
        cell_value <= next_item.value;
        in_valid <= 1'b1;
        items_offered++;
        hold_left = sender_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure: mostly ready, with stalls of random length
  always @(negedge clk) begin : drain_results
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left = idle_len();
    end
  end

  // monitor: predicts on every input transfer, checks every output transfer
  always @(posedge clk) begin : watch_ports
    item_t seen;
    outcome_t due;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.kind = kind;
        seen.row = row;
        seen.col = col;
        seen.value = cell_value;
        if (predict_item(seen, due)) due_results.push_back(due);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %0d/%0d/%0b",
                   $time, read_value, sweeps_used, converged);
          fail_count++;
        end else begin
          due = due_results.pop_front();
          compare_field("read_value", longint'(due.value), longint'(read_value));
          compare_field("sweeps_used", longint'(due.sweeps), longint'(sweeps_used));
          compare_field("converged", longint'(due.settled), longint'(converged));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    bit narrow;
    int phase_count;
    int roll;
    logic [lgs_pkg::POS_W-1:0] r;
    logic [lgs_pkg::POS_W-1:0] c;
    logic [lgs_pkg::TOL_W-1:0] tol;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset edge value, two sweeps: init first so no cell is ever undefined
    set_registers(lgs_pkg::TOP_EDGE_RST, lgs_pkg::TOLERANCE_RST, 16'd2);
    push_item(lgs_pkg::KIND_INIT, 0, 0, 0);
    push_item(lgs_pkg::KIND_READ, 0, 0, 0);
    push_item(lgs_pkg::KIND_READ, 0, 1, 0);
    push_item(lgs_pkg::KIND_READ, 0, 31, 0);
    push_item(lgs_pkg::KIND_READ, 31, 0, 0);
    push_item(lgs_pkg::KIND_WRITE, 0, 0, 32'sh7fff_ffff);
    push_item(lgs_pkg::KIND_WRITE, 31, 31, 32'sh8000_0000);
    push_item(lgs_pkg::KIND_WRITE, 15, 16, -1);
    push_item(lgs_pkg::KIND_WRITE, 1, 30, 32'sh7fff_ffff);
    push_item(lgs_pkg::KIND_READ, 0, 0, 0);
    push_item(lgs_pkg::KIND_READ, 31, 31, 0);
    push_item(lgs_pkg::KIND_READ, 15, 16, 0);
    push_item(lgs_pkg::KIND_SOLVE, 0, 0, 0);
    push_item(lgs_pkg::KIND_READ, 1, 1, 0);
    push_item(lgs_pkg::KIND_READ, 30, 30, 0);
    push_item(lgs_pkg::KIND_READ, 1, 30, 0);

    // sweep limit of zero: no sweep at all, reported unconverged
    quiesce();
    set_registers(32'sh8000_0000, 16'hffff, 16'd0);
    push_item(lgs_pkg::KIND_INIT, 0, 0, 0);
    push_item(lgs_pkg::KIND_SOLVE, 0, 0, 0);
    push_item(lgs_pkg::KIND_READ, 0, 30, 0);

    // all-zero grid with zero tolerance settles after one sweep despite the huge limit
    quiesce();
    set_registers('0, 16'd0, 16'hffff);
    push_item(lgs_pkg::KIND_INIT, 0, 0, 0);
    push_item(lgs_pkg::KIND_SOLVE, 31, 31, 32'sh7fff_ffff);
    push_item(lgs_pkg::KIND_READ, 16, 16, 0);

    // largest edge value stresses the accumulator next to the top row
    quiesce();
    set_registers(32'sh7fff_ffff, 16'hffff, 16'd1);
    push_item(lgs_pkg::KIND_INIT, 0, 0, 0);
    push_item(lgs_pkg::KIND_SOLVE, 0, 0, 0);
    push_item(lgs_pkg::KIND_READ, 1, 15, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // every phase change waits for the block to drain completely
      quiesce();
      narrow = 1'($urandom_range(0, 1));
      calm = (p == 2);
      case ($urandom_range(0, 4))
        0:       tol = '0;
        1:       tol = 16'hffff;
        2:       tol = lgs_pkg::TOL_W'($urandom_range(0, 300));
        default: tol = lgs_pkg::TOL_W'($urandom);
      endcase
      set_registers(pick_value(narrow), tol, lgs_pkg::SWEEP_W'($urandom_range(1, 3)));
      push_item(lgs_pkg::KIND_INIT, lgs_pkg::POS_W'($urandom), lgs_pkg::POS_W'($urandom),
                $urandom);
      phase_count = 1;
      while (phase_count < PHASE_ITEMS) begin
        roll = $urandom_range(0, 999);
        r = lgs_pkg::POS_W'($urandom);
        c = lgs_pkg::POS_W'($urandom);
        if (roll < 30) begin
          push_item(lgs_pkg::KIND_SOLVE, r, c, $urandom);
          phase_count++;
        end else if (roll < 50) begin
          push_item(lgs_pkg::KIND_INIT, r, c, $urandom);
          phase_count++;
        end else if (roll < 250) begin
          // write then read back the same cell
          push_item(lgs_pkg::KIND_WRITE, r, c, pick_value(narrow));
          push_item(lgs_pkg::KIND_READ, r, c, $urandom);
          phase_count += 2;
        end else if (roll < 620) begin
          push_item(lgs_pkg::KIND_WRITE, r, c, pick_value(narrow));
          phase_count++;
        end else begin
          push_item(lgs_pkg::KIND_READ, r, c, $urandom);
          phase_count++;
        end
      end
    end

    quiesce();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
